// ===== rtl/pbr_pkg.sv =====
package pbr_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 20;

  // register indexes of the configuration port
  localparam logic [CfgIndexW-1:0] REG_LINKAGE_ENABLE   = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_DAY_TARGET       = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_NIGHT_TARGET     = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_BAND_HALF_WIDTH  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_DAY_START_MINUTE = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_DAY_END_MINUTE   = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_PERSIST_TICKS    = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_HOLD_TICKS       = 3'd7;

  // relay command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_OFF  = 2'd1;
  localparam logic [1:0] CMD_ON   = 2'd2;

  localparam logic [7:0]  BAND_HALF_WIDTH_RESET = 8'd2;
  localparam logic [7:0]  PERSIST_TICKS_RESET   = 8'd60;
  localparam logic [19:0] HOLD_TICKS_RESET      = 20'd900;

  localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
  localparam logic [4:0]  LAST_HOUR        = 5'd23;
  localparam logic [3:0]  FIRST_MONTH      = 4'd1;
  localparam logic [3:0]  LAST_MONTH       = 4'd12;
  localparam logic [7:0]  RUN_COUNT_MAX    = 8'd255;

  typedef struct packed {
    logic               linkage_enable;
    logic signed [10:0] day_target;
    logic signed [10:0] night_target;
    logic [7:0]         band_half_width;
    logic [10:0]        day_start_minute;
    logic [10:0]        day_end_minute;
    logic [7:0]         persist_ticks;
    logic [19:0]        hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [3:0]         month;
    logic               sensor_present;
    logic               relay_is_on;
    logic               manual_lock;
  } item_t;

  typedef struct packed {
    logic       over_flag;
    logic       under_flag;
    logic [1:0] relay_command;
    logic       hold_active;
  } result_t;

endpackage

// ===== rtl/pbr_cfg.sv =====
module pbr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pbr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pbr_pkg::CfgDataW-1:0]  cfg_data,
  output pbr_pkg::cfg_t                 cfg
);
  import pbr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linkage_enable   <= 1'b0;
      cfg.day_target       <= '0;
      cfg.night_target     <= '0;
      cfg.band_half_width  <= BAND_HALF_WIDTH_RESET;
      cfg.day_start_minute <= '0;
      cfg.day_end_minute   <= '0;
      cfg.persist_ticks    <= PERSIST_TICKS_RESET;
      cfg.hold_ticks       <= HOLD_TICKS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINKAGE_ENABLE:   cfg.linkage_enable   <= cfg_data[0];
        REG_DAY_TARGET:       cfg.day_target       <= cfg_data[10:0];
        REG_NIGHT_TARGET:     cfg.night_target     <= cfg_data[10:0];
        REG_BAND_HALF_WIDTH:  cfg.band_half_width  <= cfg_data[7:0];
        REG_DAY_START_MINUTE: cfg.day_start_minute <= cfg_data[10:0];
        REG_DAY_END_MINUTE:   cfg.day_end_minute   <= cfg_data[10:0];
        REG_PERSIST_TICKS:    cfg.persist_ticks    <= cfg_data[7:0];
        REG_HOLD_TICKS:       cfg.hold_ticks       <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pbr_core.sv =====
module pbr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  pbr_pkg::item_t   item,
  input  pbr_pkg::cfg_t    cfg,
  output pbr_pkg::result_t res
);
  import pbr_pkg::*;

  logic [7:0]  over_run_count;
  logic [7:0]  under_run_count;
  logic        over_state;
  logic        under_state;
  logic [19:0] hold_remaining;

  logic [7:0]  over_run_count_next;
  logic [7:0]  under_run_count_next;
  logic        over_state_next;
  logic        under_state_next;
  logic [19:0] hold_remaining_next;

  logic               active;
  logic [10:0]        minute_of_day;
  logic               is_day;
  logic signed [10:0] target;
  logic signed [11:0] hi_units;
  logic signed [11:0] lo_units;
  logic signed [15:0] hi_ext;
  logic signed [15:0] lo_ext;
  logic signed [15:0] hi;
  logic signed [15:0] lo;
  logic signed [31:0] hi32;
  logic signed [31:0] lo32;
  logic               over_cond;
  logic               under_cond;
  logic [8:0]         over_step;
  logic [8:0]         under_step;
  logic               blocked;
  logic               turn_on;
  logic [1:0]         cmd;

  // returns {toggle, new count}
  function automatic logic [8:0] run_tick(input logic [7:0] cnt, input logic cond,
                                          input logic [7:0] persist);
    logic [7:0] n;
    n = (cnt < RUN_COUNT_MAX) ? cnt + 8'd1 : RUN_COUNT_MAX;
    if (!cond) begin
      run_tick = 9'd0;
    end else if (n > persist) begin
      run_tick = {1'b1, 8'd0};
    end else begin
      run_tick = {1'b0, n};
    end
  endfunction

  always_comb begin
    active = cfg.linkage_enable && item.sensor_present &&
             (item.month >= FIRST_MONTH) && (item.month <= LAST_MONTH) &&
             (item.hour <= LAST_HOUR);
    minute_of_day = 11'(item.hour) * MINUTES_PER_HOUR + 11'(item.minute);
    is_day = (minute_of_day >= cfg.day_start_minute) &&
             (minute_of_day <= cfg.day_end_minute);
    target = is_day ? cfg.day_target : cfg.night_target;

    hi_units = {target[10], target} + $signed({4'b0000, cfg.band_half_width});
    lo_units = {target[10], target} - $signed({4'b0000, cfg.band_half_width});
    hi_ext = {{4{hi_units[11]}}, hi_units};
    lo_ext = {{4{lo_units[11]}}, lo_units};
    // times ten as x*8 + x*2
    hi = (hi_ext <<< 3) + (hi_ext <<< 1);
    lo = (lo_ext <<< 3) + (lo_ext <<< 1);
    hi32 = {{16{hi[15]}}, hi};
    lo32 = {{16{lo[15]}}, lo};

    over_cond  = over_state  ? (item.sample < hi32) : (item.sample > hi32);
    under_cond = under_state ? (item.sample > lo32) : (item.sample < lo32);
    over_step  = run_tick(over_run_count, over_cond, cfg.persist_ticks);
    under_step = run_tick(under_run_count, under_cond, cfg.persist_ticks);

    blocked = hold_remaining != 20'd0;

    over_run_count_next  = over_run_count;
    under_run_count_next = under_run_count;
    over_state_next      = over_state;
    under_state_next     = under_state;
    if (active) begin
      over_run_count_next  = over_step[7:0];
      under_run_count_next = under_step[7:0];
      over_state_next      = over_state ^ over_step[8];
      under_state_next     = under_state ^ under_step[8];
    end

    cmd     = CMD_NONE;
    turn_on = 1'b0;
    if (active && !item.manual_lock) begin
      if (over_state_next) begin
        if (item.relay_is_on) begin
          cmd = CMD_OFF;
        end
      end else if (under_state_next && !blocked && !item.relay_is_on) begin
        cmd     = CMD_ON;
        turn_on = 1'b1;
      end
    end

    // the hold counts down on every tick while nonzero, whether the item is active or not
    hold_remaining_next = blocked ? hold_remaining - 20'd1 : hold_remaining;
    if (turn_on) begin
      hold_remaining_next = cfg.hold_ticks;
    end

    res.over_flag     = over_state_next;
    res.under_flag    = under_state_next;
    res.relay_command = cmd;
    res.hold_active   = hold_remaining_next != 20'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      over_run_count  <= '0;
      under_run_count <= '0;
      over_state      <= 1'b0;
      under_state     <= 1'b0;
      hold_remaining  <= '0;
    end else if (step) begin
      over_run_count  <= over_run_count_next;
      under_run_count <= under_run_count_next;
      over_state      <= over_state_next;
      under_state     <= under_state_next;
      hold_remaining  <= hold_remaining_next;
    end
  end

endmodule

// ===== rtl/persistent_band_on_off_regulator.sv =====
// On/off regulator with a persistence-qualified band. One regulation tick per
// input transfer; a new tick is taken every cycle as long as the result side
// keeps up. A tick is held in the input register and its result is then
// captured in the result register, which raises out_valid; the move into the
// result register stalls while an untaken result is still held there, and the
// input register then holds its tick as well. The throughput of one tick per
// cycle, while the result side keeps up, rests on the core updating the run
// counters, flags and hold counter on every step. Configuration writes take
// effect in the cycle after their transfer and are always accepted.
module persistent_band_on_off_regulator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pbr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pbr_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            sample,
  input  logic [4:0]                    hour,
  input  logic [5:0]                    minute,
  input  logic [3:0]                    month,
  input  logic                          sensor_present,
  input  logic                          relay_is_on,
  input  logic                          manual_lock,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          over_flag,
  output logic                          under_flag,
  output logic [1:0]                    relay_command,
  output logic                          hold_active
);
  import pbr_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t core_res;
  result_t out_res;
  logic    out_load;
  logic    step;

  assign out_load = !out_valid || out_ready;
  assign step     = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  pbr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s1_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= '{sample, hour, minute, month, sensor_present, relay_is_on, manual_lock};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= core_res;
    end
  end

  assign over_flag     = out_res.over_flag;
  assign under_flag    = out_res.under_flag;
  assign relay_command = out_res.relay_command;
  assign hold_active   = out_res.hold_active;

`ifndef NO_ASSERTIONS
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (relay_command == CMD_NONE || relay_command == CMD_OFF ||
                   relay_command == CMD_ON))
    else $error("relay command code out of range");

  a_on_not_over: assert property (@(posedge clk) disable iff (rst)
    (out_valid && relay_command == CMD_ON) |-> !over_flag)
    else $error("turn-on issued while over flag set");

  a_on_starts_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && relay_command == CMD_ON && cfg.hold_ticks != '0) |-> hold_active)
    else $error("turn-on did not start the hold");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule
